// ----- hw/rtl/pse_pkg.sv -----
package pse_pkg;

	localparam int PC_W = 5;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_STAR  = 8'h2a;
	localparam logic [7:0] CH_SLASH = 8'h2f;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_UNDER = 3'd1,
		ST_OVER  = 3'd2,
		ST_DIVZ  = 3'd3,
		ST_BADCH = 3'd4
	} status_t;

	typedef enum logic [4:0] {
		A_NONE,
		A_LATCH,
		A_SET_BADCH,
		A_PUSH,
		A_SET_OVER,
		A_RD_RHS,
		A_RD_LHS,
		A_CAP_LHS,
		A_ADDSUB,
		A_MUL_INIT,
		A_MUL_STEP,
		A_MUL_WR,
		A_DIV_INIT,
		A_DIV_STEP,
		A_DIV_WR,
		A_SET_DIVZ,
		A_SET_UNDER,
		A_RD_TOP,
		A_OUT_TOP,
		A_OUT_ERR
	} act_t;

	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_IN,
		C_ERR,
		C_IS_OP,
		C_IS_DIGIT,
		C_FULL,
		C_UNDER2,
		C_IS_DIV,
		C_IS_MUL,
		C_ITER,
		C_RHS_ZERO,
		C_NOT_LAST,
		C_NO_TOP,
		C_OUT_BUSY
	} cond_t;

	typedef struct packed {
		act_t             act;
		cond_t            cond;
		logic [PC_W-1:0]  target;
	} uword_t;

	localparam logic [PC_W-1:0] P_FETCH = 5'd0;
	localparam logic [PC_W-1:0] P_PUSH  = 5'd5;
	localparam logic [PC_W-1:0] P_OVFL  = 5'd7;
	localparam logic [PC_W-1:0] P_OPER  = 5'd8;
	localparam logic [PC_W-1:0] P_MUL   = 5'd15;
	localparam logic [PC_W-1:0] P_MULL  = 5'd16;
	localparam logic [PC_W-1:0] P_DIV   = 5'd18;
	localparam logic [PC_W-1:0] P_DIVL  = 5'd20;
	localparam logic [PC_W-1:0] P_DIVZ  = 5'd22;
	localparam logic [PC_W-1:0] P_UNDF  = 5'd23;
	localparam logic [PC_W-1:0] P_FIN   = 5'd24;
	localparam logic [PC_W-1:0] P_TOPW  = 5'd27;
	localparam logic [PC_W-1:0] P_ERRW  = 5'd29;

	function automatic uword_t ucode(input logic [PC_W-1:0] pc);
		uword_t w;
		unique case (pc)
			5'd0:  w = '{A_LATCH,     C_NO_IN,    P_FETCH};
			5'd1:  w = '{A_NONE,      C_ERR,      P_FIN};
			5'd2:  w = '{A_NONE,      C_IS_OP,    P_OPER};
			5'd3:  w = '{A_NONE,      C_IS_DIGIT, P_PUSH};
			5'd4:  w = '{A_SET_BADCH, C_ALWAYS,   P_FIN};
			5'd5:  w = '{A_NONE,      C_FULL,     P_OVFL};
			5'd6:  w = '{A_PUSH,      C_ALWAYS,   P_FIN};
			5'd7:  w = '{A_SET_OVER,  C_ALWAYS,   P_FIN};
			5'd8:  w = '{A_NONE,      C_UNDER2,   P_UNDF};
			5'd9:  w = '{A_RD_RHS,    C_NEVER,    P_FETCH};
			5'd10: w = '{A_RD_LHS,    C_NEVER,    P_FETCH};
			5'd11: w = '{A_CAP_LHS,   C_NEVER,    P_FETCH};
			5'd12: w = '{A_NONE,      C_IS_DIV,   P_DIV};
			5'd13: w = '{A_NONE,      C_IS_MUL,   P_MUL};
			5'd14: w = '{A_ADDSUB,    C_ALWAYS,   P_FIN};
			5'd15: w = '{A_MUL_INIT,  C_NEVER,    P_FETCH};
			5'd16: w = '{A_MUL_STEP,  C_ITER,     P_MULL};
			5'd17: w = '{A_MUL_WR,    C_ALWAYS,   P_FIN};
			5'd18: w = '{A_NONE,      C_RHS_ZERO, P_DIVZ};
			5'd19: w = '{A_DIV_INIT,  C_NEVER,    P_FETCH};
			5'd20: w = '{A_DIV_STEP,  C_ITER,     P_DIVL};
			5'd21: w = '{A_DIV_WR,    C_ALWAYS,   P_FIN};
			5'd22: w = '{A_SET_DIVZ,  C_ALWAYS,   P_FIN};
			5'd23: w = '{A_SET_UNDER, C_ALWAYS,   P_FIN};
			5'd24: w = '{A_NONE,      C_NOT_LAST, P_FETCH};
			5'd25: w = '{A_NONE,      C_NO_TOP,   P_ERRW};
			5'd26: w = '{A_RD_TOP,    C_NEVER,    P_FETCH};
			5'd27: w = '{A_NONE,      C_OUT_BUSY, P_TOPW};
			5'd28: w = '{A_OUT_TOP,   C_ALWAYS,   P_FETCH};
			5'd29: w = '{A_NONE,      C_OUT_BUSY, P_ERRW};
			5'd30: w = '{A_OUT_ERR,   C_ALWAYS,   P_FETCH};
			default: w = '{A_NONE,    C_ALWAYS,   P_FETCH};
		endcase
		return w;
	endfunction

endpackage

// ----- hw/rtl/pse_in_if.sv -----
interface pse_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] symbol;
	logic       last;

	modport source (output valid, symbol, last, input ready);
	modport sink (input valid, symbol, last, output ready);
	modport monitor (input valid, ready, symbol, last);
endinterface

// ----- hw/rtl/pse_out_if.sv -----
interface pse_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] value;
	logic [2:0]         status;

	modport source (output valid, value, status, input ready);
	modport sink (input valid, value, status, output ready);
	modport monitor (input valid, ready, value, status);
endinterface

// ----- hw/rtl/postfix_stack_evaluator.sv -----
// flow: a word runs its microcode steps from acceptance; a last word then puts out the top of
// the stack or an error code, waiting while a held result is not yet taken
// throughput: one word at a time, the shared shift-add / restoring divide loop
// retires one bit per cycle and the stack memory has a single registered read port
// reset: arst_n clears the step counter, stack pointer, error code and result valid;
// the stack memory is not cleared and needs no clearing pass
module postfix_stack_evaluator #(
	parameter int STACK_DEPTH = 16,
	parameter int VALUE_WIDTH = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	pse_in_if.sink   symbols,
	pse_out_if.source results
);
	import pse_pkg::*;

	localparam int W   = VALUE_WIDTH;
	localparam int AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int SPW = $clog2(STACK_DEPTH + 1);
	localparam int CW  = $clog2(VALUE_WIDTH);

	logic [W-1:0]    mem [STACK_DEPTH];
	logic [W-1:0]    rdata_q;

	logic [PC_W-1:0] pc_q, pc_d;
	uword_t          uw;
	logic            cond;

	logic [SPW-1:0]  sp_q;
	status_t         err_q;
	logic [7:0]      sym_q;
	logic            last_q;
	logic [CW-1:0]   cnt_q;
	logic [W-1:0]    lhs_q, rhs_q, acc_q, a_q, b_q;

	logic            out_valid_q;
	logic [31:0]     value_q;
	logic [2:0]      status_q;

	logic [SPW-1:0]  sp_m1, sp_m2;
	logic            is_digit, is_op, out_busy;
	logic            we, re;
	logic [AW-1:0]   waddr, raddr;
	logic [W-1:0]    wdata;
	logic [W-1:0]    lhs_mag, rhs_mag, quo;
	logic [W:0]      shifted, diff;

	assign uw       = ucode(pc_q);
	assign sp_m1    = sp_q - SPW'(1);
	assign sp_m2    = sp_q - SPW'(2);
	assign is_digit = (sym_q >= CH_ZERO) && (sym_q <= CH_NINE);
	assign is_op    = (sym_q == CH_PLUS) || (sym_q == CH_MINUS) ||
	                  (sym_q == CH_STAR) || (sym_q == CH_SLASH);
	assign out_busy = out_valid_q && !results.ready;

	assign lhs_mag  = lhs_q[W-1] ? (W'(0) - lhs_q) : lhs_q;
	assign rhs_mag  = rhs_q[W-1] ? (W'(0) - rhs_q) : rhs_q;
	assign shifted  = {acc_q, a_q[W-1]};
	assign diff     = shifted - {1'b0, b_q};
	assign quo      = (lhs_q[W-1] ^ rhs_q[W-1]) ? (W'(0) - a_q) : a_q;

	assign symbols.ready  = (uw.act == A_LATCH);
	assign results.valid  = out_valid_q;
	assign results.value  = value_q;
	assign results.status = status_q;

	always_comb begin
		unique case (uw.cond)
			C_NEVER:    cond = 1'b0;
			C_ALWAYS:   cond = 1'b1;
			C_NO_IN:    cond = !symbols.valid;
			C_ERR:      cond = (err_q != ST_OK);
			C_IS_OP:    cond = is_op;
			C_IS_DIGIT: cond = is_digit;
			C_FULL:     cond = (sp_q == SPW'(STACK_DEPTH));
			C_UNDER2:   cond = (sp_q < SPW'(2));
			C_IS_DIV:   cond = (sym_q == CH_SLASH);
			C_IS_MUL:   cond = (sym_q == CH_STAR);
			C_ITER:     cond = (cnt_q != CW'(VALUE_WIDTH - 1));
			C_RHS_ZERO: cond = (rhs_q == '0);
			C_NOT_LAST: cond = !last_q;
			C_NO_TOP:   cond = (err_q != ST_OK) || (sp_q == '0);
			C_OUT_BUSY: cond = out_busy;
			default:    cond = 1'b0;
		endcase
	end

	always_comb begin
		pc_d = cond ? uw.target : pc_q + PC_W'(1);
	end

	always_comb begin
		we    = 1'b0;
		re    = 1'b0;
		waddr = sp_m2[AW-1:0];
		raddr = sp_m1[AW-1:0];
		wdata = acc_q;
		unique case (uw.act)
			A_PUSH: begin
				we    = 1'b1;
				waddr = sp_q[AW-1:0];
				wdata = W'(4'(sym_q - CH_ZERO));
			end
			A_ADDSUB: begin
				we    = 1'b1;
				wdata = (sym_q == CH_PLUS) ? lhs_q + rhs_q : lhs_q - rhs_q;
			end
			A_MUL_WR: begin
				we    = 1'b1;
			end
			A_DIV_WR: begin
				we    = 1'b1;
				wdata = quo;
			end
			A_RD_RHS, A_RD_TOP: begin
				re    = 1'b1;
			end
			A_RD_LHS: begin
				re    = 1'b1;
				raddr = sp_m2[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= P_FETCH;
			sp_q        <= '0;
			err_q       <= ST_OK;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			pc_q <= pc_d;
			if (uw.act == A_OUT_TOP || uw.act == A_OUT_ERR) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (uw.act)
				A_SET_BADCH: err_q <= ST_BADCH;
				A_SET_OVER:  err_q <= ST_OVER;
				A_SET_DIVZ:  err_q <= ST_DIVZ;
				A_SET_UNDER: err_q <= ST_UNDER;
				A_PUSH:      sp_q  <= sp_q + SPW'(1);
				A_ADDSUB, A_MUL_WR, A_DIV_WR: sp_q <= sp_m1;
				A_MUL_INIT, A_DIV_INIT: cnt_q <= '0;
				A_MUL_STEP, A_DIV_STEP: cnt_q <= cnt_q + CW'(1);
				A_OUT_TOP, A_OUT_ERR: begin
					sp_q        <= '0;
					err_q       <= ST_OK;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (uw.act)
			A_LATCH: begin
				if (symbols.valid) begin
					sym_q  <= symbols.symbol;
					last_q <= symbols.last;
				end
			end
			A_RD_LHS:  rhs_q <= rdata_q;
			A_CAP_LHS: lhs_q <= rdata_q;
			A_MUL_INIT: begin
				acc_q <= '0;
				a_q   <= lhs_q;
				b_q   <= rhs_q;
			end
			A_MUL_STEP: begin
				if (b_q[0]) begin
					acc_q <= acc_q + a_q;
				end
				a_q <= {a_q[W-2:0], 1'b0};
				b_q <= {1'b0, b_q[W-1:1]};
			end
			A_DIV_INIT: begin
				acc_q <= '0;
				a_q   <= lhs_mag;
				b_q   <= rhs_mag;
			end
			A_DIV_STEP: begin
				if (!diff[W]) begin
					acc_q <= diff[W-1:0];
					a_q   <= {a_q[W-2:0], 1'b1};
				end else begin
					acc_q <= shifted[W-1:0];
					a_q   <= {a_q[W-2:0], 1'b0};
				end
			end
			A_OUT_TOP: begin
				value_q  <= 32'($signed(rdata_q));
				status_q <= ST_OK;
			end
			A_OUT_ERR: begin
				value_q  <= '0;
				status_q <= (err_q != ST_OK) ? err_q : ST_UNDER;
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- hw/rtl/pse_checker.sv -----
module pse_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] out_value,
	input logic [2:0]         out_status
);
	import pse_pkg::*;

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_value) && $stable(out_status))
		else $error("result word changed while stalled");

	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready while a word is in work");

	a_load_not_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result loaded during fetch");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_status != ST_OK) |-> (out_value == 32'sd0))
		else $error("nonzero value with error status");

endmodule

bind postfix_stack_evaluator pse_checker u_pse_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (symbols.valid),
	.in_ready   (symbols.ready),
	.out_valid  (results.valid),
	.out_ready  (results.ready),
	.out_value  (results.value),
	.out_status (results.status)
);
